// ===== hw/rtl/mec_pkg.sv =====
// shared types, constants and the hue table of the mandelbrot escape colour block
package mec_pkg;

  localparam int FRAC_BITS = 24;

  localparam int COORD_W = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ORG_W   = 32;
  localparam int STEP_W  = 31;
  localparam int CPROD_W = COORD_W + STEP_W;
  localparam int C_W     = CPROD_W + 2;

  // z saturates at +-2048, so it needs 12 integer bits and a sign
  localparam int Z_W    = FRAC_BITS + 13;
  localparam int LO_W   = 18;
  localparam int HI_W   = Z_W - LO_W;
  localparam int PP_W   = 2 * HI_W;
  localparam int PROD_W = 2 * Z_W;
  localparam int SQ_W   = FRAC_BITS + 24;
  localparam int RI_W   = FRAC_BITS + 25;
  localparam int SUM_W  = RI_W + 1;
  localparam int MAG_W  = SQ_W;

  localparam int CNT_W = 6;
  localparam int ESC_W = 5;
  localparam int COL_W = 8;

  localparam logic signed [SUM_W-1:0] Z_LIMIT = SUM_W'(64'sd2048 <<< FRAC_BITS);
  localparam logic [MAG_W-1:0] ESC_LIMIT  = MAG_W'(64'd1000000 << FRAC_BITS);
  localparam logic [MAG_W-1:0] SLOW_LIMIT = MAG_W'(64'd4 << FRAC_BITS);

  localparam logic [CNT_W-1:0] SLOW_HUE = CNT_W'(20);

  localparam logic [COL_W-1:0] DARK_RED   = 8'd43;
  localparam logic [COL_W-1:0] DARK_GREEN = 8'd44;
  localparam logic [COL_W-1:0] DARK_BLUE  = 8'd90;
  localparam logic [COL_W-1:0] FULL       = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REAL_ORIGIN = 2'd0,
    CFG_IMAG_ORIGIN = 2'd1,
    CFG_REAL_STEP   = 2'd2,
    CFG_IMAG_STEP   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REGION_INSIDE  = 2'd0,
    REGION_ESCAPED = 2'd1,
    REGION_SLOW    = 2'd2
  } region_t;

  // one pixel as it travels down the cell chain
  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [C_W-1:0]   cr;
    logic signed [C_W-1:0]   ci;
    logic signed [Z_W-1:0]   zr;
    logic signed [Z_W-1:0]   zi;
    logic [MAG_W-1:0]        mag;
    logic                    done;
    logic [CNT_W-1:0]        count;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    rgb_t               col;
    logic [ESC_W-1:0]   escape_count;
    region_t            region;
  } res_t;

  // 255 * xs / 6, truncated
  function automatic logic [COL_W-1:0] hue_level(input logic [2:0] xs);
    logic [COL_W-1:0] v;
    case (xs)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd42;
      3'd2:    v = 8'd85;
      3'd3:    v = 8'd127;
      3'd4:    v = 8'd170;
      3'd5:    v = 8'd212;
      3'd6:    v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // hue in tens of degrees, full saturation and value
  function automatic rgb_t hue_to_rgb(input logic [CNT_W-1:0] tens);
    logic [2:0]       sec;
    logic [2:0]       j;
    logic [COL_W-1:0] up;
    logic [COL_W-1:0] dn;
    rgb_t             c;
    if (tens < CNT_W'(6)) begin
      sec = 3'd0;
      j   = tens[2:0];
    end else if (tens < CNT_W'(12)) begin
      sec = 3'd1;
      j   = 3'(tens - CNT_W'(6));
    end else if (tens < CNT_W'(18)) begin
      sec = 3'd2;
      j   = 3'(tens - CNT_W'(12));
    end else if (tens < CNT_W'(24)) begin
      sec = 3'd3;
      j   = 3'(tens - CNT_W'(18));
    end else if (tens < CNT_W'(30)) begin
      sec = 3'd4;
      j   = 3'(tens - CNT_W'(24));
    end else begin
      sec = 3'd5;
      j   = 3'(tens - CNT_W'(30));
    end
    up = hue_level(j);
    dn = hue_level(3'(3'd6 - j));
    case (sec)
      3'd0:    c = '{red: FULL,  green: up,    blue: 8'd0};
      3'd1:    c = '{red: dn,    green: FULL,  blue: 8'd0};
      3'd2:    c = '{red: 8'd0,  green: FULL,  blue: up};
      3'd3:    c = '{red: 8'd0,  green: dn,    blue: FULL};
      3'd4:    c = '{red: up,    green: 8'd0,  blue: FULL};
      3'd5:    c = '{red: FULL,  green: 8'd0,  blue: dn};
      default: c = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/mec_if.sv =====
// pixel and result channel interfaces
interface mec_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mec_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_x;
  logic [7:0] out_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [4:0] escape_count;
  logic [1:0] region;

  modport source (output valid, out_x, out_y, red, green, blue, escape_count, region,
                  input ready);
  modport sink (input valid, out_x, out_y, red, green, blue, escape_count, region,
                output ready);
endinterface

// ===== hw/rtl/mandelbrot_escape_colour_top.sv =====
// mandelbrot escape colour: pixel position in, escape count and colour out
// an accepted word passes the entry registers, the iteration cells and the colour output register
// one word per cycle while results are taken: a chain of MAX_ITER+1 three-stage iteration cells, all pixels in flight
// a result word not taken holds the whole chain, and the input stalls with it
// reset clears every valid bit and loads the default origin and step registers
module mandelbrot_escape_colour_top #(
  parameter int MAX_ITER = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mec_pix_if.sink                         in_px,
  mec_res_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mec_pkg::CFG_W-1:0]       cfg_wdata
);

  logic signed [mec_pkg::ORG_W-1:0] real_origin_r, imag_origin_r;
  logic [mec_pkg::STEP_W-1:0]       real_step_r, imag_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_origin_r <= 32'shFF00_0000;
      imag_origin_r <= 32'shFF00_0000;
      real_step_r   <= 31'd167772;
      imag_step_r   <= 31'd167772;
    end else if (cfg_we) begin
      case (mec_pkg::cfg_idx_t'(cfg_idx))
        mec_pkg::CFG_REAL_ORIGIN: real_origin_r <= cfg_wdata;
        mec_pkg::CFG_IMAG_ORIGIN: imag_origin_r <= cfg_wdata;
        mec_pkg::CFG_REAL_STEP:   real_step_r   <= cfg_wdata[mec_pkg::STEP_W-1:0];
        mec_pkg::CFG_IMAG_STEP:   imag_step_r   <= cfg_wdata[mec_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic          adv;
  logic          out_v;
  mec_pkg::res_t res;

  assign adv         = !out_v || out_res.ready;
  assign in_px.ready = adv;

  // entry: position times step, then add origin
  logic                          e1_v_r;
  logic [mec_pkg::COORD_W-1:0]   e1_x_r, e1_y_r;
  logic [mec_pkg::CPROD_W-1:0]   e1_prx_r, e1_pry_r;
  logic                          e2_v_r;
  mec_pkg::item_t                e2_item_r;
  mec_pkg::item_t                e2_item_nxt;

  always_comb begin
    e2_item_nxt.x     = e1_x_r;
    e2_item_nxt.y     = e1_y_r;
    e2_item_nxt.cr    = mec_pkg::C_W'(real_origin_r) + $signed(mec_pkg::C_W'(e1_prx_r));
    e2_item_nxt.ci    = mec_pkg::C_W'(imag_origin_r) + $signed(mec_pkg::C_W'(e1_pry_r));
    e2_item_nxt.zr    = '0;
    e2_item_nxt.zi    = '0;
    e2_item_nxt.mag   = '0;
    e2_item_nxt.done  = 1'b0;
    e2_item_nxt.count = mec_pkg::CNT_W'(MAX_ITER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
    end else if (adv) begin
      e1_v_r <= in_px.valid;
      e2_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_x_r    <= in_px.pixel_x;
      e1_y_r    <= in_px.pixel_y;
      e1_prx_r  <= mec_pkg::CPROD_W'(in_px.pixel_x) * mec_pkg::CPROD_W'(real_step_r);
      e1_pry_r  <= mec_pkg::CPROD_W'(in_px.pixel_y) * mec_pkg::CPROD_W'(imag_step_r);
      e2_item_r <= e2_item_nxt;
    end
  end

  // cell k takes z after k steps; the last cell only tests the final step
  logic           chain_v    [0:MAX_ITER+1];
  mec_pkg::item_t chain_item [0:MAX_ITER+1];

  assign chain_v[0]    = e2_v_r;
  assign chain_item[0] = e2_item_r;

  for (genvar g = 0; g <= MAX_ITER; g++) begin : g_cell
    mec_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_v     (chain_v[g]),
      .in_item  (chain_item[g]),
      .out_v    (chain_v[g+1]),
      .out_item (chain_item[g+1])
    );
  end

  mec_colour u_colour (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (chain_v[MAX_ITER+1]),
    .in_item (chain_item[MAX_ITER+1]),
    .out_v   (out_v),
    .res     (res)
  );

  assign out_res.valid        = out_v;
  assign out_res.out_x        = res.x;
  assign out_res.out_y        = res.y;
  assign out_res.red          = res.col.red;
  assign out_res.green        = res.col.green;
  assign out_res.blue         = res.col.blue;
  assign out_res.escape_count = res.escape_count;
  assign out_res.region       = res.region;

endmodule

// ===== hw/rtl/mec_cell.sv =====
// one iteration cell: squares of z, escape test on |z|^2, next z
module mec_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  mec_pkg::item_t  in_item,
  output logic            out_v,
  output mec_pkg::item_t  out_item
);

  function automatic logic signed [mec_pkg::PROD_W-1:0] pp_sum(
    input logic signed [mec_pkg::PP_W-1:0] hh,
    input logic signed [mec_pkg::PP_W-1:0] hl,
    input logic signed [mec_pkg::PP_W-1:0] lh,
    input logic signed [mec_pkg::PP_W-1:0] ll
  );
    return (mec_pkg::PROD_W'(hh) <<< (2 * mec_pkg::LO_W))
         + (mec_pkg::PROD_W'(hl) <<< mec_pkg::LO_W)
         + (mec_pkg::PROD_W'(lh) <<< mec_pkg::LO_W)
         + mec_pkg::PROD_W'(ll);
  endfunction

  function automatic logic signed [mec_pkg::Z_W-1:0] clamp_z(
    input logic signed [mec_pkg::SUM_W-1:0] v
  );
    logic signed [mec_pkg::Z_W-1:0] r;
    if (v > mec_pkg::Z_LIMIT) begin
      r = mec_pkg::Z_W'(mec_pkg::Z_LIMIT);
    end else if (v < -mec_pkg::Z_LIMIT) begin
      r = mec_pkg::Z_W'(-mec_pkg::Z_LIMIT);
    end else begin
      r = mec_pkg::Z_W'(v);
    end
    return r;
  endfunction

  // split z into a signed high half and a zero-extended low half
  logic signed [mec_pkg::HI_W-1:0] zr_h, zr_l, zi_h, zi_l;

  assign zr_h = in_item.zr[mec_pkg::Z_W-1:mec_pkg::LO_W];
  assign zi_h = in_item.zi[mec_pkg::Z_W-1:mec_pkg::LO_W];
  assign zr_l = $signed(mec_pkg::HI_W'(in_item.zr[mec_pkg::LO_W-1:0]));
  assign zi_l = $signed(mec_pkg::HI_W'(in_item.zi[mec_pkg::LO_W-1:0]));

  // stage 1: partial products
  logic                            s1_v_r;
  mec_pkg::item_t                  s1_item_r;
  logic signed [mec_pkg::PP_W-1:0] rr_hh_r, rr_hl_r, rr_ll_r;
  logic signed [mec_pkg::PP_W-1:0] ii_hh_r, ii_hl_r, ii_ll_r;
  logic signed [mec_pkg::PP_W-1:0] ri_hh_r, ri_hl_r, ri_lh_r, ri_ll_r;

  // stage 2: floored products
  logic                            s2_v_r;
  mec_pkg::item_t                  s2_item_r;
  logic [mec_pkg::SQ_W-1:0]        rr_r, ii_r;
  logic signed [mec_pkg::RI_W-1:0] ri_r;
  logic signed [mec_pkg::PROD_W-1:0] rr_full, ii_full, ri_full;

  // stage 3: escape test and next z
  logic                             s3_v_r;
  mec_pkg::item_t                   s3_item_r;
  mec_pkg::item_t                   s3_item_nxt;
  logic [mec_pkg::MAG_W-1:0]        mag;
  logic signed [mec_pkg::SUM_W-1:0] zr_sum, zi_sum;
  logic                             esc;

  assign rr_full = pp_sum(rr_hh_r, rr_hl_r, rr_hl_r, rr_ll_r);
  assign ii_full = pp_sum(ii_hh_r, ii_hl_r, ii_hl_r, ii_ll_r);
  assign ri_full = pp_sum(ri_hh_r, ri_hl_r, ri_lh_r, ri_ll_r);

  always_comb begin
    mag    = mec_pkg::MAG_W'(rr_r) + mec_pkg::MAG_W'(ii_r);
    zr_sum = $signed(mec_pkg::SUM_W'(rr_r)) - $signed(mec_pkg::SUM_W'(ii_r))
           + mec_pkg::SUM_W'(s2_item_r.cr);
    zi_sum = mec_pkg::SUM_W'(ri_r) + mec_pkg::SUM_W'(s2_item_r.ci);
    // the incoming z is the result of step IDX
    esc    = (IDX > 0) && !s2_item_r.done && (mag > mec_pkg::ESC_LIMIT);
    s3_item_nxt     = s2_item_r;
    s3_item_nxt.zr  = clamp_z(zr_sum);
    s3_item_nxt.zi  = clamp_z(zi_sum);
    s3_item_nxt.mag = mag;
    if (esc) begin
      s3_item_nxt.done  = 1'b1;
      s3_item_nxt.count = mec_pkg::CNT_W'(IDX > 0 ? IDX - 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= in_item;
      rr_hh_r   <= zr_h * zr_h;
      rr_hl_r   <= zr_h * zr_l;
      rr_ll_r   <= zr_l * zr_l;
      ii_hh_r   <= zi_h * zi_h;
      ii_hl_r   <= zi_h * zi_l;
      ii_ll_r   <= zi_l * zi_l;
      ri_hh_r   <= zr_h * zi_h;
      ri_hl_r   <= zr_h * zi_l;
      ri_lh_r   <= zr_l * zi_h;
      ri_ll_r   <= zr_l * zi_l;

      s2_item_r <= s1_item_r;
      rr_r      <= rr_full[mec_pkg::FRAC_BITS +: mec_pkg::SQ_W];
      ii_r      <= ii_full[mec_pkg::FRAC_BITS +: mec_pkg::SQ_W];
      // 2*zr*zi is one less bit of shift
      ri_r      <= ri_full[mec_pkg::FRAC_BITS-1 +: mec_pkg::RI_W];

      s3_item_r <= s3_item_nxt;
    end
  end

  assign out_v    = s3_v_r;
  assign out_item = s3_item_r;

endmodule

// ===== hw/rtl/mec_colour.sv =====
// region decision, hue lookup and the output register
module mec_colour (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  mec_pkg::item_t  in_item,
  output logic            out_v,
  output mec_pkg::res_t   res
);

  logic           out_v_r;
  mec_pkg::res_t  res_r;
  mec_pkg::res_t  res_nxt;

  always_comb begin
    res_nxt.x            = in_item.x;
    res_nxt.y            = in_item.y;
    res_nxt.escape_count = in_item.count[mec_pkg::ESC_W-1:0];
    if (in_item.done) begin
      res_nxt.region = mec_pkg::REGION_ESCAPED;
      res_nxt.col    = mec_pkg::hue_to_rgb(in_item.count);
    end else if (in_item.mag > mec_pkg::SLOW_LIMIT) begin
      res_nxt.region = mec_pkg::REGION_SLOW;
      res_nxt.col    = mec_pkg::hue_to_rgb(mec_pkg::SLOW_HUE);
    end else begin
      res_nxt.region = mec_pkg::REGION_INSIDE;
      res_nxt.col    = '{red: mec_pkg::DARK_RED, green: mec_pkg::DARK_GREEN,
                         blue: mec_pkg::DARK_BLUE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_v = out_v_r;
  assign res   = res_r;

endmodule

// ===== hw/rtl/mec_chk.sv =====
// port-level checks on the result channel, bound to the top level
module mec_chk #(
  parameter int MAX_ITER = 20
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_x,
  input logic [7:0] out_y,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [4:0] escape_count,
  input logic [1:0] region
);

  localparam mec_pkg::rgb_t SLOW_COL = mec_pkg::hue_to_rgb(mec_pkg::SLOW_HUE);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_x, out_y, red, green, blue, escape_count, region}))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && region == mec_pkg::REGION_INSIDE |->
      red == mec_pkg::DARK_RED && green == mec_pkg::DARK_GREEN
      && blue == mec_pkg::DARK_BLUE && escape_count == 5'(MAX_ITER))
    else $error("inside pixel without dark colour or full count");

  a_escaped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && region == mec_pkg::REGION_ESCAPED |-> escape_count < MAX_ITER)
    else $error("escaped pixel with count past the last step");

  a_slow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && region == mec_pkg::REGION_SLOW |->
      red == SLOW_COL.red && green == SLOW_COL.green && blue == SLOW_COL.blue
      && escape_count == 5'(MAX_ITER))
    else $error("slow divergence pixel with wrong colour or count");

endmodule

bind mandelbrot_escape_colour_top mec_chk #(
  .MAX_ITER (MAX_ITER)
) u_mec_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_x        (out_res.out_x),
  .out_y        (out_res.out_y),
  .red          (out_res.red),
  .green        (out_res.green),
  .blue         (out_res.blue),
  .escape_count (out_res.escape_count),
  .region       (out_res.region)
);
